// ===== rtl/core/sdpm_pkg.sv =====
// Shared types and codes for the sparse dot product merge block.
`default_nettype none

package sdpm_pkg;

  // Item kinds on the input channel.
  localparam logic CmdRow    = 1'b0;
  localparam logic CmdColumn = 1'b1;

  localparam logic signed [63:0] AccMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] AccMin = 64'sh8000_0000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // store the accepted input transaction
    logic start;   // clear merge pointers and accumulator
    logic read;    // fetch the row and column entries at the merge pointers
    logic step;    // compare fetched positions, advance pointers, multiply on match
    logic finish;  // merge is over: drop the column list
    logic emit;    // load the result cell into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;      // both lists still have entries to walk
    logic nonzero;   // accumulated sum is nonzero
    logic out_free;  // output register can take a cell this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdpm_ctrl.sv =====
// Controller state machine: sequences loading, the merge walk and result hand-off.
`default_nettype none

module sdpm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   cmd_i,
  input  logic                   last_in_vector_i,
  output logic                   in_ready_o,
  input  sdpm_pkg::dp_status_t   status_i,
  output sdpm_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRead   = 2'd1;
  localparam logic [1:0] StCmp    = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = accept;
        if (accept && (cmd_i == sdpm_pkg::CmdColumn) && last_in_vector_i) begin
          cmd_o.start = 1'b1;
          state_d     = StRead;
        end
      end
      StRead: begin
        if (status_i.more) begin
          cmd_o.read = 1'b1;
          state_d    = StCmp;
        end else begin
          state_d = StFinish;
        end
      end
      StCmp: begin
        cmd_o.step = 1'b1;
        state_d    = StRead;
      end
      StFinish: begin
        if (!status_i.nonzero) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdpm_datapath.sv =====
// Datapath: vector memories, counters, merge pointers, multiply-accumulate, output register.
`default_nettype none

module sdpm_datapath #(
  parameter int unsigned MAX_NONZEROS = 256,
  parameter int unsigned INDEX_BITS   = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sdpm_pkg::ctrl_cmd_t        cmd_i,
  output sdpm_pkg::dp_status_t       status_o,
  input  logic                       column_offset_we_i,
  input  logic [31:0]                column_offset_i,
  input  logic                       item_cmd_i,
  input  logic                       carries_entry_i,
  input  logic [31:0]                position_i,
  input  logic signed [31:0]         entry_value_i,
  input  logic [31:0]                vector_index_i,
  input  logic                       last_in_vector_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [31:0]                cell_row_o,
  output logic [31:0]                cell_column_o,
  output logic signed [63:0]         cell_value_o
);

  localparam int unsigned CW = $clog2(MAX_NONZEROS + 1);
  localparam int unsigned AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam logic [CW-1:0] CountMax = CW'(MAX_NONZEROS);
  localparam logic [32:0] IdxMaskWide =
    (INDEX_BITS >= 32) ? {1'b0, {32{1'b1}}} : ((33'd1 << INDEX_BITS) - 33'd1);
  localparam logic [31:0] IdxMask = IdxMaskWide[31:0];

  // Entry layout: position in the upper half, value in the lower half.
  logic [63:0] row_mem [MAX_NONZEROS];
  logic [63:0] col_mem [MAX_NONZEROS];
  logic [63:0] row_rd_q, col_rd_q;

  logic [31:0]        column_offset_q;
  logic [CW-1:0]      row_count_q, col_count_q;
  logic [31:0]        row_number_q, col_index_q;
  logic               row_loading_q;
  logic [CW-1:0]      r_q, c_q;
  logic signed [63:0] acc_q, prod_q;
  logic               prod_valid_q;
  logic               out_valid_q;
  logic [31:0]        cell_row_q, cell_column_q;
  logic signed [63:0] cell_value_q;

  logic [31:0]        pos_m, vidx_m;
  logic               load_row, load_col;
  logic [CW-1:0]      row_base;
  logic               row_wr, col_wr;
  logic [63:0]        wr_entry;
  logic [31:0]        rd_row_pos, rd_col_pos;
  logic signed [31:0] rd_row_val, rd_col_val;
  logic signed [63:0] acc_sum, acc_next;
  logic               acc_ovf;
  logic [32:0]        col_sum;
  logic [31:0]        col_sat;

  assign pos_m    = position_i & IdxMask;
  assign vidx_m   = vector_index_i & IdxMask;
  assign load_row = cmd_i.load && (item_cmd_i == sdpm_pkg::CmdRow);
  assign load_col = cmd_i.load && (item_cmd_i == sdpm_pkg::CmdColumn);
  assign row_base = row_loading_q ? row_count_q : '0;
  assign row_wr   = load_row && carries_entry_i && (row_base < CountMax);
  assign col_wr   = load_col && carries_entry_i && (col_count_q < CountMax);
  assign wr_entry = {pos_m, entry_value_i};

  assign rd_row_pos = row_rd_q[63:32];
  assign rd_row_val = row_rd_q[31:0];
  assign rd_col_pos = col_rd_q[63:32];
  assign rd_col_val = col_rd_q[31:0];

  assign acc_sum  = acc_q + prod_q;
  assign acc_ovf  = (acc_q[63] == prod_q[63]) && (acc_sum[63] != acc_q[63]);
  assign acc_next = acc_ovf ? (prod_q[63] ? sdpm_pkg::AccMin : sdpm_pkg::AccMax) : acc_sum;

  assign col_sum = {1'b0, column_offset_q} + {1'b0, col_index_q};
  assign col_sat = (col_sum > IdxMaskWide) ? IdxMask : col_sum[31:0];

  assign status_o.more     = (r_q < row_count_q) && (c_q < col_count_q);
  assign status_o.nonzero  = (acc_q != '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (row_wr) begin
      row_mem[row_base[AW-1:0]] <= wr_entry;
    end
    if (cmd_i.read) begin
      row_rd_q <= row_mem[r_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (col_wr) begin
      col_mem[col_count_q[AW-1:0]] <= wr_entry;
    end
    if (cmd_i.read) begin
      col_rd_q <= col_mem[c_q[AW-1:0]];
    end
  end

  // Loading and configuration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_offset_q <= '0;
      row_count_q     <= '0;
      row_number_q    <= '0;
      row_loading_q   <= 1'b0;
      col_count_q     <= '0;
    end else begin
      if (column_offset_we_i) begin
        column_offset_q <= column_offset_i;
      end
      if (load_row) begin
        if (!row_loading_q) begin
          row_number_q <= vidx_m;
        end
        row_loading_q <= !last_in_vector_i;
        row_count_q   <= row_wr ? row_base + CW'(1) : row_base;
      end
      if (col_wr) begin
        col_count_q <= col_count_q + CW'(1);
      end else if (cmd_i.finish) begin
        col_count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_col && last_in_vector_i) begin
      col_index_q <= vidx_m;
    end
  end

  // Merge walk and multiply-accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q          <= '0;
      c_q          <= '0;
      acc_q        <= '0;
      prod_valid_q <= 1'b0;
    end else if (cmd_i.start) begin
      r_q          <= '0;
      c_q          <= '0;
      acc_q        <= '0;
      prod_valid_q <= 1'b0;
    end else begin
      if (prod_valid_q) begin
        acc_q <= acc_next;
      end
      if (cmd_i.step) begin
        if (rd_col_pos < rd_row_pos) begin
          c_q <= c_q + CW'(1);
        end else if (rd_col_pos > rd_row_pos) begin
          r_q <= r_q + CW'(1);
        end else begin
          r_q          <= r_q + CW'(1);
          c_q          <= c_q + CW'(1);
          prod_valid_q <= 1'b1;
        end
      end else begin
        prod_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      prod_q <= 64'(rd_row_val) * 64'(rd_col_val);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      cell_row_q    <= row_number_q;
      cell_column_q <= col_sat;
      cell_value_q  <= acc_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_row_o    = cell_row_q;
  assign cell_column_o = cell_column_q;
  assign cell_value_o  = cell_value_q;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_dot_product_merge.sv =====
// Top level of the sparse row-times-column dot product merge block.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one nonzero per transaction.
//   cmd_i = 0 loads a row of A, which is kept for all later columns; cmd_i = 1
//   loads a column of transposed B. Items with carries_entry_i = 0 mark empty
//   vectors. The column transaction with last_in_vector_i set starts a merge of
//   the two sorted position lists; matching positions are multiplied (Q16.16 x
//   Q16.16 -> Q32.32) and summed with 64-bit saturation.
//   A nonzero sum leaves as one cell on the output channel (out_valid_o /
//   out_ready_i): row, column_offset + local column (saturated), value.
//   column_offset_we_i / column_offset_i write the offset; write only when idle.
// Sequence:
//   Loading accepts a new transaction every clock while in_ready_o is high. A
//   column-ending transaction starts the walk; each walk step is a memory read, then
//   compare and multiply, and the walk ends with a last pointer check and the
//   hand-off; the walk takes at most row length + column length - 1 steps.
//   in_ready_o is low while a merge runs.
// Reset clears counts, the row-loading flag, the offset and the output valid.
// On a receiver stall the cell holds in the output register, new items still
// load, and a following merge holds its result until the register frees up.
`default_nettype none

module sparse_dot_product_merge #(
  parameter int unsigned MAX_NONZEROS = 256,
  parameter int unsigned INDEX_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                column_offset_we_i,
  input  logic [31:0]         column_offset_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic                carries_entry_i,
  input  logic [31:0]         position_i,
  input  logic signed [31:0]  entry_value_i,
  input  logic [31:0]         vector_index_i,
  input  logic                last_in_vector_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         cell_row_o,
  output logic [31:0]         cell_column_o,
  output logic signed [63:0]  cell_value_o
);

  sdpm_pkg::ctrl_cmd_t  ctrl_cmd;
  sdpm_pkg::dp_status_t dp_status;

  sdpm_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .cmd_i            (cmd_i),
    .last_in_vector_i (last_in_vector_i),
    .in_ready_o       (in_ready_o),
    .status_i         (dp_status),
    .cmd_o            (ctrl_cmd)
  );

  sdpm_datapath #(
    .MAX_NONZEROS (MAX_NONZEROS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .column_offset_we_i (column_offset_we_i),
    .column_offset_i    (column_offset_i),
    .item_cmd_i         (cmd_i),
    .carries_entry_i    (carries_entry_i),
    .position_i         (position_i),
    .entry_value_i      (entry_value_i),
    .vector_index_i     (vector_index_i),
    .last_in_vector_i   (last_in_vector_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .cell_row_o         (cell_row_o),
    .cell_column_o      (cell_column_o),
    .cell_value_o       (cell_value_o)
  );

endmodule

`default_nettype wire
